// ===== hdl/pttp_pkg.sv =====
// Shared constants and types for the point transform / perspective divide block.
package pttp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int QDEPTH        = 8;
    localparam int QAW           = 3;
    localparam int QUO_BITS      = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 4'd0,
        REG_ROW0_COLS23 = 4'd1,
        REG_ROW1_COLS01 = 4'd2,
        REG_ROW1_COLS23 = 4'd3,
        REG_ROW2_COLS01 = 4'd4,
        REG_ROW2_COLS23 = 4'd5,
        REG_ROW3_COLS01 = 4'd6,
        REG_ROW3_COLS23 = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic room;
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== hdl/point_transform_perspective_top.sv =====
// Top level: point transform by a 4x4 matrix with perspective divide.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata = x_in, y_in, z_in
//   m_       out  m_tvalid/m_tready    m_tdata = x_out, y_out, z_out; m_tuser = w_was_zero
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (64-bit, two entries of one matrix row)
//
// One word per cycle while m_ is not stalled; path: 3 multiply/sum stages, queue,
// setup, 33 quotient-bit stages, output register. The divide pipeline sets the depth.
// Reset loads the identity matrix. cfg_ready is always high.
// An m_ stall freezes the divide pipeline; s_ keeps accepting until the 8-entry queue
// credit runs out.
module point_transform_perspective_top #(
    parameter int FRAC_BITS = pttp_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,   // x_in, y_in, z_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [95:0]                    m_tdata,   // x_out, y_out, z_out
    output logic                           m_tuser,   // w_was_zero
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pttp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import pttp_pkg::*;

    localparam int SW = 67 - FRAC_BITS;

    logic            s_acc;
    logic            push, q_valid, pop;
    logic [4*SW-1:0] push_data, q_data;
    qstat_t          qstat;

    assign cfg_ready = 1'b1;
    assign s_tready  = qstat.room;
    assign s_acc     = s_tvalid && s_tready;

    pttp_front #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_front (
        .aclk, .aresetn,
        .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
        .in_valid(s_acc), .in_data(s_tdata),
        .push, .push_data
    );

    pttp_queue #(.DW(4*SW)) u_queue (
        .aclk, .aresetn,
        .reserve(s_acc), .push, .push_data,
        .pop, .out_valid(q_valid), .out_data(q_data), .stat(qstat)
    );

    pttp_back #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_data(q_data), .pop,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata), .out_wz(m_tuser)
    );

    a_front_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |-> ##3 push) else $error("front lost a word");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !push || pop) else $error("queue overflow");

    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !s_tready) else $error("credit out of step with queue");

endmodule

// ===== hdl/pttp_front.sv =====
// Matrix registers and the 3-stage multiply / column-sum pipeline.
module pttp_front #(
    parameter int FRAC_BITS = pttp_pkg::FRAC_BITS_DEF,
    parameter int SW        = 67 - FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pttp_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [63:0]                       cfg_val,
    input  logic                              in_valid,
    input  logic [95:0]                       in_data,
    output logic                              push,
    output logic [4*SW-1:0]                   push_data
);
    import pttp_pkg::*;

    logic [63:0]        mat_reg [0:NUM_REGS-1];
    logic signed [63:0] prod_reg [0:2][0:3];
    logic signed [65:0] psum_reg [0:3];
    logic signed [SW-1:0] sum_reg [0:3];
    logic [2:0]         v_reg;
    logic signed [31:0] pt [0:2];

    assign pt[0] = in_data[31:0];
    assign pt[1] = in_data[63:32];
    assign pt[2] = in_data[95:64];

    function automatic logic signed [31:0] ent(input logic [63:0] r, input int c);
        return (c % 2 == 1) ? r[63:32] : r[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[0] <= 64'h0000_0000_0001_0000;
            mat_reg[1] <= 64'h0;
            mat_reg[2] <= 64'h0001_0000_0000_0000;
            mat_reg[3] <= 64'h0;
            mat_reg[4] <= 64'h0;
            mat_reg[5] <= 64'h0000_0000_0001_0000;
            mat_reg[6] <= 64'h0;
            mat_reg[7] <= 64'h0001_0000_0000_0000;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_ROW0_COLS01: mat_reg[0] <= cfg_val;
                REG_ROW0_COLS23: mat_reg[1] <= cfg_val;
                REG_ROW1_COLS01: mat_reg[2] <= cfg_val;
                REG_ROW1_COLS23: mat_reg[3] <= cfg_val;
                REG_ROW2_COLS01: mat_reg[4] <= cfg_val;
                REG_ROW2_COLS23: mat_reg[5] <= cfg_val;
                REG_ROW3_COLS01: mat_reg[6] <= cfg_val;
                REG_ROW3_COLS23: mat_reg[7] <= cfg_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // products, then exact column sums, then floor to FRAC_BITS plus translation
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                prod_reg[r][c] <= 64'(pt[r] * ent(mat_reg[r*2 + c/2], c));
            end
        end
        for (int c = 0; c < 4; c++) begin
            psum_reg[c] <= 66'(prod_reg[0][c]) + 66'(prod_reg[1][c]) + 66'(prod_reg[2][c]);
            sum_reg[c]  <= SW'(psum_reg[c] >>> FRAC_BITS) + SW'(ent(mat_reg[6 + c/2], c));
        end
    end

    assign push      = v_reg[2];
    assign push_data = {sum_reg[3], sum_reg[2], sum_reg[1], sum_reg[0]};

endmodule

// ===== hdl/pttp_queue.sv =====
// Short queue with credit count between the transform front and divide back.
module pttp_queue #(
    parameter int DW = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                reserve,
    input  logic                push,
    input  logic [DW-1:0]       push_data,
    input  logic                pop,
    output logic                out_valid,
    output logic [DW-1:0]       out_data,
    output pttp_pkg::qstat_t    stat
);
    import pttp_pkg::*;

    logic [DW-1:0]  mem [0:QDEPTH-1];
    logic [DW-1:0]  out_reg;
    logic [QAW-1:0] wr_reg, rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next, cred_reg, cred_next;

    always_comb begin
        rd_next   = rd_reg + QAW'(pop);
        cnt_next  = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        cred_next = cred_reg + (QAW+1)'(reserve) - (QAW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cnt_reg  <= '0;
            cred_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg  <= cnt_next;
            cred_reg <= cred_next;
        end
    end

    // head word is kept registered; a write to the next head address is forwarded
    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= push_data;
        out_reg <= (push && wr_reg == rd_next) ? push_data : mem[rd_next];
    end

    assign out_valid  = (cnt_reg != '0);
    assign out_data   = out_reg;
    assign stat.room  = (cred_reg < (QAW+1)'(QDEPTH));
    assign stat.full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// ===== hdl/pttp_back.sv =====
// Perspective divide: setup stage, one quotient bit per stage, saturating output register.
module pttp_back #(
    parameter int FRAC_BITS = pttp_pkg::FRAC_BITS_DEF,
    parameter int SW        = 67 - FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [4*SW-1:0]   in_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [95:0]       out_data,
    output logic              out_wz
);
    import pttp_pkg::*;

    localparam int DW = SW + FRAC_BITS + QUO_BITS;
    localparam int QB = QUO_BITS;
    localparam logic signed [SW-1:0] MAXS = SW'(32'sh7fff_ffff);
    localparam logic signed [SW-1:0] MINS = SW'(-32'sh7fff_ffff - 32'sd1);

    logic                v_reg   [0:QB];
    logic [SW-1:0]       b_reg   [0:QB];
    logic                wz_reg  [0:QB];
    logic [DW-1:0]       rem_reg [0:QB][0:2];
    logic [QB-1:0]       q_reg   [0:QB][0:2];
    logic                neg_reg [0:QB][0:2];
    logic                ovf_reg [0:QB][0:2];
    logic [31:0]         sat_reg [0:QB][0:2];
    logic                ov_reg;
    logic [31:0]         res_reg [0:2];
    logic                owz_reg;
    logic                en;

    logic signed [SW-1:0] s [0:3];
    logic [SW-1:0]        bmag;
    logic [SW-1:0]        amag [0:2];
    logic [DW-1:0]        num  [0:2];
    logic [31:0]          res  [0:2];

    assign en  = !ov_reg || out_ready;
    assign pop = en && in_valid;

    always_comb begin
        for (int c = 0; c < 4; c++) s[c] = in_data[c*SW +: SW];
        bmag = s[3][SW-1] ? SW'(-s[3]) : SW'(s[3]);
        for (int l = 0; l < 3; l++) begin
            amag[l] = s[l][SW-1] ? SW'(-s[l]) : SW'(s[l]);
            num[l]  = DW'(amag[l]) << FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QB; i++) v_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= QB; i++) v_reg[i] <= v_reg[i-1];
            ov_reg <= v_reg[QB];
        end
    end

    // setup stage
    always_ff @(posedge aclk) begin
        if (en) begin
            b_reg[0]  <= bmag;
            wz_reg[0] <= (s[3] == '0);
            for (int l = 0; l < 3; l++) begin
                rem_reg[0][l] <= num[l];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= s[l][SW-1] ^ s[3][SW-1];
                ovf_reg[0][l] <= num[l] >= (DW'(bmag) << QB);
                sat_reg[0][l] <= (s[l] > MAXS) ? 32'h7fff_ffff :
                                 (s[l] < MINS) ? 32'h8000_0000 : s[l][31:0];
            end
        end
    end

    // restoring divide, quotient bit QB-i at stage i
    for (genvar i = 1; i <= QB; i++) begin : g_div
        logic [DW-1:0] t;
        assign t = DW'(b_reg[i-1]) << (QB - i);
        always_ff @(posedge aclk) begin
            if (en) begin
                b_reg[i]  <= b_reg[i-1];
                wz_reg[i] <= wz_reg[i-1];
                for (int l = 0; l < 3; l++) begin
                    neg_reg[i][l] <= neg_reg[i-1][l];
                    ovf_reg[i][l] <= ovf_reg[i-1][l];
                    sat_reg[i][l] <= sat_reg[i-1][l];
                    if (rem_reg[i-1][l] >= t) begin
                        rem_reg[i][l] <= rem_reg[i-1][l] - t;
                        q_reg[i][l]   <= q_reg[i-1][l] | (QB'(1) << (QB - i));
                    end else begin
                        rem_reg[i][l] <= rem_reg[i-1][l];
                        q_reg[i][l]   <= q_reg[i-1][l];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (wz_reg[QB]) begin
                res[l] = sat_reg[QB][l];
            end else if (ovf_reg[QB][l]) begin
                res[l] = neg_reg[QB][l] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else if (neg_reg[QB][l]) begin
                res[l] = (q_reg[QB][l] > 33'h0_8000_0000) ? 32'h8000_0000
                                                          : 32'(-q_reg[QB][l]);
            end else begin
                res[l] = (q_reg[QB][l] > 33'h0_7fff_ffff) ? 32'h7fff_ffff
                                                          : q_reg[QB][l][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) res_reg[l] <= res[l];
            owz_reg <= wz_reg[QB];
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = {res_reg[2], res_reg[1], res_reg[0]};
    assign out_wz    = owz_reg;

endmodule
